@@ rtl/ptbt_pkg.sv @@
package ptbt_pkg;

    // Sizing of the tally tables
    localparam int DETECTORS = 4;
    localparam int MAX_BINS  = 16;
    localparam int SLOTS     = DETECTORS * MAX_BINS;

    localparam int DET_W  = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_W = $clog2(MAX_BINS + 1);

    // Fixed field widths
    localparam int MODE_FW = 2;
    localparam int DET_FW  = 2;
    localparam int BIN_FW  = 4;
    localparam int TIME_FW = 32;
    localparam int WGT_FW  = 32;
    localparam int CFG_FW  = 5;
    localparam int CNT_FW  = 40;
    localparam int SUM_FW  = 64;

    localparam logic [CFG_FW-1:0] BINS_RESET = CFG_FW'(16);
    localparam logic [CNT_FW-1:0] COUNT_MAX  = {CNT_FW{1'b1}};

    typedef enum logic [MODE_FW-1:0] {
        MODE_LOAD = 2'd0,
        MODE_REC  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_TRD,
        ST_UPD,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic srch;
        logic tly_rd;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic [TIME_FW-1:0] finish;
        logic [TIME_FW-1:0] start;
    } t_bound;

endpackage

@@ rtl/ptbt_match.sv @@
module ptbt_match
    import ptbt_pkg::*;
(
    input  t_bound              i_row [MAX_BINS],
    input  logic [TIME_FW-1:0]  i_time,
    input  logic [USED_W-1:0]   i_used,
    output logic                o_hit,
    output logic [BIN_W-1:0]    o_idx
);

    logic [BIN_W-1:0] w_last;

    assign w_last = BIN_W'(int'(i_used) - 1);

    // Priority-select the first closed bin that holds the time, else try the open last bin
    always_comb begin
        o_hit = 1'b0;
        o_idx = w_last;
        for (int i = MAX_BINS - 1; i >= 0; i--) begin
            if ((i + 1 < int'(i_used)) && (i_time >= i_row[i].start)
                    && (i_time < i_row[i].finish)) begin
                o_hit = 1'b1;
                o_idx = BIN_W'(i);
            end
        end
        if (!o_hit) begin
            o_hit = (i_time >= i_row[w_last].start);
        end
    end

endmodule

@@ rtl/ptbt_dpath.sv @@
module ptbt_dpath
    import ptbt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [CFG_FW-1:0]   i_bins_in_use,
    input  logic [MODE_FW-1:0]  i_mode,
    input  logic [DET_FW-1:0]   i_det,
    input  logic [BIN_FW-1:0]   i_bin,
    input  logic [TIME_FW-1:0]  i_time,
    input  logic [WGT_FW-1:0]   i_weight,
    input  logic [TIME_FW-1:0]  i_bstart,
    input  logic [TIME_FW-1:0]  i_bfinish,
    output logic                o_found,
    output logic [BIN_FW-1:0]   o_taken,
    output logic [CNT_FW-1:0]   o_cnt,
    output logic [SUM_FW-1:0]   o_wsum,
    output logic [SUM_FW-1:0]   o_total
);

    // Captured transaction
    t_mode                r_mode;
    logic [DET_FW-1:0]    r_det;
    logic [BIN_FW-1:0]    r_bin;
    logic [TIME_FW-1:0]   r_time;
    logic [WGT_FW-1:0]    r_weight;
    logic [TIME_FW-1:0]   r_bstart;
    logic [TIME_FW-1:0]   r_bfinish;

    // Storage
    t_bound               r_bnd_mem [DETECTORS][MAX_BINS];
    t_bound               r_row [MAX_BINS];
    logic [CNT_FW-1:0]    r_cnt_mem [SLOTS];
    logic [SUM_FW-1:0]    r_wgt_mem [SLOTS];
    logic [SLOTS-1:0]     r_tly_vld;
    logic [SUM_FW-1:0]    r_tot [DETECTORS];

    // Search result and tally read data
    logic                 r_hit;
    logic [BIN_W-1:0]     r_idx;
    logic [SLOT_W-1:0]    r_addr;
    logic [CNT_FW-1:0]    r_cnt_q;
    logic [SUM_FW-1:0]    r_wsum_q;
    logic                 r_vld_q;

    // Result register
    logic                 r_out_found;
    logic [BIN_FW-1:0]    r_out_taken;
    logic [CNT_FW-1:0]    r_out_cnt;
    logic [SUM_FW-1:0]    r_out_wsum;
    logic [SUM_FW-1:0]    r_out_total;

    logic [USED_W-1:0]    w_used;
    logic                 w_hit;
    logic [BIN_W-1:0]     w_idx;
    logic                 w_det_ok;
    logic                 w_bin_ok;
    logic [DET_W-1:0]     w_det_idx;
    logic [BIN_W-1:0]     w_bin_idx;
    logic [BIN_W-1:0]     w_sel_idx;
    logic [SLOT_W-1:0]    w_slot;
    logic [CNT_FW-1:0]    w_cnt_cur;
    logic [SUM_FW-1:0]    w_wsum_cur;
    logic [SUM_FW-1:0]    w_tot_cur;
    logic [CNT_FW-1:0]    w_cnt_new;
    logic [SUM_FW:0]      w_wsum_add;
    logic [SUM_FW:0]      w_tot_add;
    logic [SUM_FW-1:0]    w_wsum_new;
    logic [SUM_FW-1:0]    w_tot_new;
    logic                 w_act;
    logic                 w_tally_wr;
    logic                 w_tot_wr;

    // Clamp the bin count to one through the table depth
    always_comb begin
        if (i_bins_in_use == '0) begin
            w_used = USED_W'(1);
        end else if (int'(i_bins_in_use) > MAX_BINS) begin
            w_used = USED_W'(MAX_BINS);
        end else begin
            w_used = USED_W'(i_bins_in_use);
        end
    end

    ptbt_match u_match (
        .i_row  (r_row),
        .i_time (r_time),
        .i_used (w_used),
        .o_hit  (w_hit),
        .o_idx  (w_idx)
    );

    assign w_det_ok  = int'(r_det) < DETECTORS;
    assign w_bin_ok  = int'(r_bin) < MAX_BINS;
    assign w_det_idx = DET_W'(r_det);
    assign w_bin_idx = BIN_W'(r_bin);
    assign w_act     = w_det_ok && (r_mode != MODE_NONE);
    assign w_sel_idx = (r_mode == MODE_REC) ? w_idx : w_bin_idx;
    assign w_slot    = SLOT_W'(int'(w_det_idx) * MAX_BINS + int'(w_sel_idx));

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= t_mode'(i_mode);
            r_det     <= i_det;
            r_bin     <= i_bin;
            r_time    <= i_time;
            r_weight  <= i_weight;
            r_bstart  <= i_bstart;
            r_bfinish <= i_bfinish;
        end
    end

    // Bounds memory: row read on capture, single-entry write on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= r_bnd_mem[DET_W'(i_det)];
        end
        if (i_cmd.srch && w_act && w_bin_ok && (r_mode == MODE_LOAD)) begin
            r_bnd_mem[w_det_idx][w_bin_idx] <= '{finish: r_bfinish, start: r_bstart};
        end
    end

    // Latch the search result and the tally address
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch) begin
            r_hit  <= (r_mode == MODE_REC) && w_hit;
            r_idx  <= w_idx;
            r_addr <= w_slot;
        end
    end

    // Tally memories: registered read, write back on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.tly_rd) begin
            r_cnt_q  <= r_cnt_mem[r_addr];
            r_wsum_q <= r_wgt_mem[r_addr];
        end
        if (w_tally_wr) begin
            r_cnt_mem[r_addr] <= w_cnt_new;
            r_wgt_mem[r_addr] <= w_wsum_new;
        end
    end

    // Unwritten tally entries read as zero
    assign w_cnt_cur  = r_vld_q ? r_cnt_q : '0;
    assign w_wsum_cur = r_vld_q ? r_wsum_q : '0;
    assign w_tot_cur  = r_tot[w_det_idx];

    // Saturating increments
    assign w_cnt_new  = (w_cnt_cur == COUNT_MAX) ? w_cnt_cur : w_cnt_cur + CNT_FW'(1);
    assign w_wsum_add = {1'b0, w_wsum_cur} + (SUM_FW + 1)'(r_weight);
    assign w_tot_add  = {1'b0, w_tot_cur} + (SUM_FW + 1)'(r_weight);
    assign w_wsum_new = w_wsum_add[SUM_FW] ? {SUM_FW{1'b1}} : w_wsum_add[SUM_FW-1:0];
    assign w_tot_new  = w_tot_add[SUM_FW] ? {SUM_FW{1'b1}} : w_tot_add[SUM_FW-1:0];

    assign w_tot_wr   = i_cmd.upd && w_act && (r_mode == MODE_REC);
    assign w_tally_wr = w_tot_wr && r_hit;

    // Valid bits, detector totals and read-data flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tly_vld <= '0;
            r_vld_q   <= 1'b0;
            for (int d = 0; d < DETECTORS; d++) begin
                r_tot[d] <= '0;
            end
        end else begin
            if (i_cmd.tly_rd) begin
                r_vld_q <= r_tly_vld[r_addr];
            end
            if (w_tally_wr) begin
                r_tly_vld[r_addr] <= 1'b1;
            end
            if (w_tot_wr) begin
                r_tot[w_det_idx] <= w_tot_new;
            end
        end
    end

    // Form the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_found <= 1'b0;
            r_out_taken <= '0;
            r_out_cnt   <= '0;
            r_out_wsum  <= '0;
            r_out_total <= '0;
        end else if (i_cmd.upd) begin
            r_out_found <= 1'b0;
            r_out_taken <= '0;
            r_out_cnt   <= '0;
            r_out_wsum  <= '0;
            r_out_total <= '0;
            if (w_act) begin
                if (r_mode == MODE_REC) begin
                    r_out_total <= w_tot_new;
                    if (r_hit) begin
                        r_out_found <= 1'b1;
                        r_out_taken <= BIN_FW'(r_idx);
                        r_out_cnt   <= w_cnt_new;
                        r_out_wsum  <= w_wsum_new;
                    end
                end else begin
                    r_out_total <= w_tot_cur;
                    if (w_bin_ok) begin
                        r_out_cnt  <= w_cnt_cur;
                        r_out_wsum <= w_wsum_cur;
                    end
                end
            end
        end
    end

    assign o_found = r_out_found;
    assign o_taken = r_out_taken;
    assign o_cnt   = r_out_cnt;
    assign o_wsum  = r_out_wsum;
    assign o_total = r_out_total;

`ifndef SYNTHESIS
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_found |-> (r_out_taken == '0))
        else $error("result without a bin carries a bin index");

    a_cnt_zero_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_cnt == '0) |-> (r_out_wsum == '0))
        else $error("bin with zero count has a weight sum");

    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tally_wr |=> r_tly_vld[$past(r_addr)])
        else $error("tally write left entry invalid");
`endif

endmodule

@@ rtl/ptbt_ctrl.sv @@
module ptbt_ctrl
    import ptbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence capture, search, tally read, update, deliver
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SRCH;
                end
            end
            ST_SRCH: begin
                o_cmd.srch = 1'b1;
                n_state    = ST_TRD;
            end
            ST_TRD: begin
                o_cmd.tly_rd = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and result sides open together");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_cmd.srch)
        else $error("accepted transaction not searched");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> o_out_valid)
        else $error("update not followed by result");
`endif

endmodule

@@ rtl/photon_time_bin_tally.sv @@
// Channel    Dir  Data                                              Side
// s_axis     in   tuser: mode; tdata: detector..bound_finish        one transaction per item
// m_axis     out  tuser: bin_found; tdata: bin_taken..total         one result per item
// cfg        in   i_cfg_wr_data: bins_in_use                        written on i_cfg_wr_en
//
// The result is offered after capture with bounds row read, bin search,
// tally memory read and saturating update; it holds until taken.
// The next item can be accepted in the cycle after the result is taken, so
// items never overlap: no new item is taken before the last one is done.
// A stall on m_axis holds the result and keeps s_axis_tready low.
// Synchronous active-low reset clears all counts, sums, totals and sets bins_in_use to 16.
module photon_time_bin_tally
    import ptbt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [1:0] detector, [5:2] bin_index, [37:6] photon_time, [69:38] photon_weight,
    // [101:70] bound_start, [133:102] bound_finish, [135:134] zero
    input  logic [135:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [3:0] bin_taken, [43:4] count_out, [107:44] weight_sum_out,
    // [171:108] detector_total_out, [175:172] zero
    output logic [175:0]  m_axis_tdata,
    // [0] bin_found
    output logic          m_axis_tuser,
    input  logic          i_cfg_wr_en,
    input  logic [4:0]    i_cfg_wr_data
);

    logic [CFG_FW-1:0]  r_bins_in_use;
    t_cmd               w_cmd;
    logic               w_found;
    logic [BIN_FW-1:0]  w_taken;
    logic [CNT_FW-1:0]  w_cnt;
    logic [SUM_FW-1:0]  w_wsum;
    logic [SUM_FW-1:0]  w_total;

    // Hold the bin count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_in_use <= BINS_RESET;
        end else if (i_cfg_wr_en) begin
            r_bins_in_use <= i_cfg_wr_data;
        end
    end

    ptbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    ptbt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_bins_in_use (r_bins_in_use),
        .i_mode        (s_axis_tuser),
        .i_det         (s_axis_tdata[1:0]),
        .i_bin         (s_axis_tdata[5:2]),
        .i_time        (s_axis_tdata[37:6]),
        .i_weight      (s_axis_tdata[69:38]),
        .i_bstart      (s_axis_tdata[101:70]),
        .i_bfinish     (s_axis_tdata[133:102]),
        .o_found       (w_found),
        .o_taken       (w_taken),
        .o_cnt         (w_cnt),
        .o_wsum        (w_wsum),
        .o_total       (w_total)
    );

    // Pack the result
    assign m_axis_tdata = {4'b0000, w_total, w_wsum, w_cnt, w_taken};
    assign m_axis_tuser = w_found;

endmodule

@@ dv/photon_time_bin_tally_check.sv @@
`timescale 1ns / 1ps

// Watch both stream channels and the config port of photon_time_bin_tally.
// Predict the tallies of each accepted item and compare each returned result
// against the oldest outstanding prediction.
module photon_time_bin_tally_check
    import ptbt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [175:0] i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [4:0]   i_cfg_wr_data,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Input transaction fields, lowest bits last
    typedef struct packed {
        logic [1:0]         pad;
        logic [TIME_FW-1:0] finish;
        logic [TIME_FW-1:0] start;
        logic [WGT_FW-1:0]  weight;
        logic [TIME_FW-1:0] ptime;
        logic [BIN_FW-1:0]  bin;
        logic [DET_FW-1:0]  det;
    } photon_fields_t;

    // Output tdata fields, lowest bits last
    typedef struct packed {
        logic [3:0]        pad;
        logic [SUM_FW-1:0] total;
        logic [SUM_FW-1:0] wsum;
        logic [CNT_FW-1:0] count;
        logic [BIN_FW-1:0] taken;
    } result_bus_t;

    typedef struct packed {
        logic              found;
        logic [BIN_FW-1:0] taken;
        logic [CNT_FW-1:0] count;
        logic [SUM_FW-1:0] wsum;
        logic [SUM_FW-1:0] total;
    } tally_t;

    logic [TIME_FW-1:0] start_tbl  [SLOTS];
    logic [TIME_FW-1:0] finish_tbl [SLOTS];
    logic [CNT_FW-1:0]  count_tbl  [SLOTS];
    logic [SUM_FW-1:0]  wsum_tbl   [SLOTS];
    logic [SUM_FW-1:0]  det_total  [DETECTORS];
    logic [CFG_FW-1:0]  bins_reg;
    tally_t             pending_tallies [$];
    int                 mismatches;

    function automatic logic [SUM_FW-1:0] sat_add(input logic [SUM_FW-1:0] a,
                                                  input logic [SUM_FW-1:0] b);
        logic [SUM_FW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_FW] ? {SUM_FW{1'b1}} : s[SUM_FW-1:0];
    endfunction

    // Apply one item to the tally tables and return the result it should produce
    function automatic tally_t tally_photon(input t_mode mode, input photon_fields_t f);
        tally_t r;
        int     base;
        int     nbins;
        int     i;
        int     slot;
        logic   hit;
        r    = '0;
        hit  = 1'b0;
        base = int'(f.det) * MAX_BINS;
        if (mode == MODE_REC) begin
            nbins = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS) ? MAX_BINS : int'(bins_reg);
            det_total[f.det] = sat_add(det_total[f.det], {32'b0, f.weight});
            // Search the bounded bins first, then fall back on the open-ended last one
            i = 0;
            while (!hit && i < nbins - 1) begin
                if (f.ptime >= start_tbl[base+i] && f.ptime < finish_tbl[base+i])
                    hit = 1'b1;
                else
                    i++;
            end
            if (!hit) begin
                i   = nbins - 1;
                hit = f.ptime >= start_tbl[base+i];
            end
            if (hit) begin
                slot = base + i;
                if (count_tbl[slot] != COUNT_MAX)
                    count_tbl[slot] = count_tbl[slot] + 1'b1;
                wsum_tbl[slot] = sat_add(wsum_tbl[slot], {32'b0, f.weight});
                r.found = 1'b1;
                r.taken = i[BIN_FW-1:0];
                r.count = count_tbl[slot];
                r.wsum  = wsum_tbl[slot];
            end
            r.total = det_total[f.det];
        end else if (mode != MODE_NONE) begin
            slot = base + int'(f.bin);
            if (mode == MODE_LOAD) begin
                start_tbl[slot]  = f.start;
                finish_tbl[slot] = f.finish;
            end
            r.count = count_tbl[slot];
            r.wsum  = wsum_tbl[slot];
            r.total = det_total[f.det];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        tally_t      got;
        tally_t      want;
        result_bus_t bus;
        if (!i_rst_n) begin
            // Clear tallies and drop anything outstanding
            for (int k = 0; k < SLOTS; k++) begin
                start_tbl[k]  = '0;
                finish_tbl[k] = '0;
                count_tbl[k]  = '0;
                wsum_tbl[k]   = '0;
            end
            for (int d = 0; d < DETECTORS; d++)
                det_total[d] = '0;
            bins_reg = BINS_RESET;
            pending_tallies.delete();
        end else begin
            // Compare a returned transaction with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                bus       = result_bus_t'(i_m_tdata);
                got.found = i_m_tuser;
                got.taken = bus.taken;
                got.count = bus.count;
                got.wsum  = bus.wsum;
                got.total = bus.total;
                if (pending_tallies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no item outstanding: found=%0d bin=%0d",
                                 $realtime, got.found, got.taken);
                end else begin
                    want = pending_tallies.pop_front();
                    if (got.found !== want.found || got.taken !== want.taken ||
                        got.count !== want.count || got.wsum !== want.wsum ||
                        got.total !== want.total) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: tally mismatch", $realtime);
                            $display("  expected found=%0d bin=%0d count=%0d wsum=%h total=%h",
                                     want.found, want.taken, want.count, want.wsum,
                                     want.total);
                            $display("  actual   found=%0d bin=%0d count=%0d wsum=%h total=%h",
                                     got.found, got.taken, got.count, got.wsum, got.total);
                        end
                    end
                end
            end
            if (i_cfg_wr_en)
                bins_reg = i_cfg_wr_data;
            // Predict each accepted item
            if (i_s_tvalid && i_s_tready)
                pending_tallies.push_back(
                    tally_photon(t_mode'(i_s_tuser), photon_fields_t'(i_s_tdata)));
        end
        o_pending    <= pending_tallies.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ dv/photon_time_bin_tally_test.sv @@
`timescale 1ns / 1ps

module photon_time_bin_tally_test;

    import ptbt_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int ITEMS_PER_PHASE  = 240;
    localparam int PHASES           = 8;
    localparam int SETTLE_CYCLES    = 8;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic [135:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_wr_en   = 1'b0;
    logic [4:0]   i_cfg_wr_data = '0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [175:0] m_axis_tdata;
    logic         m_axis_tuser;

    int           fail_count;
    int           pending_results;
    int           cycles = 0;
    int           rx_stall = 0;
    bit           idle_on = 1'b1;
    bit           loaded [DETECTORS][MAX_BINS];
    logic [4:0]   bins_setting = BINS_RESET;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    photon_time_bin_tally uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    photon_time_bin_tally_check tally_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready = 1'b0;
            rx_stall      = $urandom_range(0, 4);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    function automatic int bins_active();
        if (bins_setting == 0)
            return 1;
        if (bins_setting > MAX_BINS)
            return MAX_BINS;
        return int'(bins_setting);
    endfunction

    // Lowest used bin of a detector whose bounds are still unloaded, or -1
    function automatic int first_missing(input logic [1:0] det);
        int n;
        n = bins_active();
        for (int i = 0; i < n; i++)
            if (!loaded[det][i])
                return i;
        return -1;
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(4095);
        endcase
    endfunction

    // Mostly ordinary bins, with zero-width, reversed and wide ones mixed in
    function automatic logic [31:0] pick_finish(input logic [31:0] start);
        case ($urandom_range(0, 9))
            0:       return start;
            1:       return start - $urandom_range(1, 300);
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF;
            default: return start + $urandom_range(1, 600);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h0000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return $urandom_range(32'h8000_0000);
        endcase
    endfunction

    // Offer one transaction, with an occasional gap ahead of it
    task automatic send(input t_mode mode, input logic [1:0] det, input logic [3:0] bin,
                        input logic [31:0] ptime, input logic [31:0] weight,
                        input logic [31:0] bstart, input logic [31:0] bfinish);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {2'b00, bfinish, bstart, weight, ptime, bin, det};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_LOAD)
            loaded[det][bin] = 1'b1;
    endtask

    // Hold off until every outstanding result has returned
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bins(input logic [4:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        bins_setting  = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Mostly records; swap a record for a load while its detector has unloaded bins
    task automatic random_item();
        t_mode       mode;
        logic [1:0]  det;
        logic [3:0]  bin;
        logic [31:0] bstart;
        int          kind;
        int          missing;
        det    = $urandom_range(0, 3);
        bin    = $urandom_range(0, 15);
        bstart = pick_time();
        kind   = $urandom_range(0, 99);
        if (kind < 55)
            mode = MODE_REC;
        else if (kind < 75)
            mode = MODE_LOAD;
        else if (kind < 95)
            mode = MODE_READ;
        else
            mode = MODE_NONE;
        missing = first_missing(det);
        if (mode == MODE_REC && missing >= 0) begin
            mode = MODE_LOAD;
            bin  = missing[3:0];
        end
        send(mode, det, bin, pick_time(), pick_weight(), bstart, pick_finish(bstart));
    endtask

    initial begin
        int bins_plan [PHASES];
        bins_plan = '{1, 31, 0, 16, 2, 17, $urandom_range(3, 15), 16};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fresh tallies read back as zero; unused mode with every bit set
        send(MODE_READ, 2'd0, 4'd0, '0, '0, '0, '0);
        send(MODE_NONE, 2'd3, 4'hF, '1, '1, '1, '1);
        send(MODE_READ, 2'd3, 4'hF, '0, '0, '0, '0);

        // Four bins: normal, zero-width, reversed, open-ended last
        write_bins(5'd4);
        send(MODE_LOAD, 2'd0, 4'd0, '0, '0, 32'd0, 32'd100);
        send(MODE_LOAD, 2'd0, 4'd1, '0, '0, 32'd100, 32'd100);
        send(MODE_LOAD, 2'd0, 4'd2, '0, '0, 32'd300, 32'd200);
        send(MODE_LOAD, 2'd0, 4'd3, '0, '0, 32'd1000, 32'hFFFF_FFFF);
        send(MODE_LOAD, 2'd0, 4'd15, '0, '0, 32'hFFFF_FFFF, 32'd0);
        send(MODE_REC, 2'd0, 4'd0, 32'd0, 32'h8000_0000, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'd99, 32'd0, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'd100, 32'h7FFF_FFFF, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'd250, 32'h0000_1234, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'd1000, 32'h4000_0000, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000, '0, '0);
        send(MODE_READ, 2'd0, 4'd3, '0, '0, '0, '0);
        send(MODE_READ, 2'd0, 4'd15, '0, '0, '0, '0);
        send(MODE_LOAD, 2'd0, 4'd0, '0, '0, 32'd50, 32'd60);
        send(MODE_REC, 2'd0, 4'd0, 32'd10, 32'h0000_0001, '0, '0);

        // Zero bins in use acts as one open-ended bin
        write_bins(5'd0);
        send(MODE_REC, 2'd0, 4'd0, 32'd5, 32'h0000_0100, '0, '0);
        send(MODE_REC, 2'd0, 4'd0, 32'd70, 32'h8000_0000, '0, '0);

        // Random traffic under each setting; the last phase runs without idling
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                idle_on = 1'b0;
            write_bins(bins_plan[p][4:0]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
                if (p == 1 && n == ITEMS_PER_PHASE / 2)
                    drain();
            end
        end

        drain();
        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ptbt_pkg.sv
rtl/ptbt_match.sv
rtl/ptbt_dpath.sv
rtl/ptbt_ctrl.sv
rtl/photon_time_bin_tally.sv
dv/photon_time_bin_tally_check.sv
dv/photon_time_bin_tally_test.sv
